// File: rtl/core/graph_vertex_merge_engine_core_defines.svh
// Assertion macros shared by the engine's modules.
`ifndef GRAPH_VERTEX_MERGE_ENGINE_CORE_DEFINES_SVH
`define GRAPH_VERTEX_MERGE_ENGINE_CORE_DEFINES_SVH

// Assert that a condition implies a consequence in the same cycle.
`define GVM_ASSERT_IMP(label, clk, rstn, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (cons)) \
        else $error(msg);

// Assert that a condition implies a consequence in the next cycle.
`define GVM_ASSERT_NEXT(label, clk, rstn, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/gvme_pkg.sv
package gvme_pkg;

    localparam int MAX_VERTICES_DEF = 32;

    localparam logic [2:0] FUNC_NEW    = 3'd0;
    localparam logic [2:0] FUNC_ADD    = 3'd1;
    localparam logic [2:0] FUNC_REMOVE = 3'd2;
    localparam logic [2:0] FUNC_QUERY  = 3'd3;
    localparam logic [2:0] FUNC_IDENT  = 3'd4;
    localparam logic [2:0] FUNC_CONTR  = 3'd5;
    localparam logic [2:0] FUNC_READ   = 3'd6;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_VERTEX = 2'd1;
    localparam logic [1:0] ST_NO_EDGE    = 2'd2;

    // Datapath commands issued by the controller.
    typedef struct packed {
        logic load;     // capture the input beat
        logic evaluate; // decide the result fields
        logic clear;    // zero all rows, set count
        logic edge_op;  // apply add or remove on row a
        logic fold;     // or row b into row a
        logic sweep;    // rewrite row at sweep index
        logic finish;   // decrement count after merge
    } dp_cmd_t;

    typedef struct packed {
        logic a_ok;
        logic b_ok;
        logic same;
        logic edge_ab;
        logic sweep_last;
    } dp_stat_t;

endpackage

// File: rtl/core/graph_vertex_merge_engine_core.sv
// Edge, query, read and new-graph operations and refused merges pass through
// evaluate and result; a merge that goes ahead also runs fold and a sweep over
// N-1 rows, N the live vertex count.
// One item at a time: the next beat is taken only once the result beat has been
// accepted.
// Reset (aresetn low, synchronous) clears the matrix and the vertex count.
module graph_vertex_merge_engine_core #(
    parameter int MAX_VERTICES = gvme_pkg::MAX_VERTICES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_func,
    input  logic [5:0]  s_vertex_a,
    input  logic [5:0]  s_vertex_b,
    input  logic [5:0]  s_vertex_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic        m_edge_present,
    output logic [31:0] m_row_bits,
    output logic [5:0]  m_vertex_total
);

    gvme_pkg::dp_cmd_t  cmd;
    gvme_pkg::dp_stat_t stat;

    // Controller: sequence one beat through evaluate, fold, sweep and result.
    gvme_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_func  (s_func),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Datapath: hold the matrix and count, rewrite rows on command.
    gvme_dp #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_func         (s_func),
        .s_vertex_a     (s_vertex_a),
        .s_vertex_b     (s_vertex_b),
        .s_vertex_count (s_vertex_count),
        .cmd            (cmd),
        .stat           (stat),
        .m_status       (m_status),
        .m_edge_present (m_edge_present),
        .m_row_bits     (m_row_bits),
        .m_vertex_total (m_vertex_total)
    );

endmodule

// File: rtl/core/gvme_ctrl.sv
module gvme_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_func,
    output logic               m_valid,
    input  logic               m_ready,
    input  gvme_pkg::dp_stat_t stat,
    output gvme_pkg::dp_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_FOLD  = 3'd2;
    localparam logic [2:0] S_SWEEP = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [2:0] func_reg, func_next;
    logic       m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == S_IDLE) && !m_valid_reg;
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        func_next    = func_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.load  = 1'b1;
                    func_next = s_func;
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                cmd.evaluate = 1'b1;
                state_next   = S_DONE;
                unique case (func_reg)
                    gvme_pkg::FUNC_NEW: begin
                        cmd.clear = 1'b1;
                    end
                    gvme_pkg::FUNC_ADD, gvme_pkg::FUNC_REMOVE: begin
                        cmd.edge_op = stat.a_ok && stat.b_ok;
                    end
                    gvme_pkg::FUNC_IDENT, gvme_pkg::FUNC_CONTR: begin
                        if (stat.a_ok && stat.b_ok && !stat.same &&
                            (func_reg == gvme_pkg::FUNC_IDENT || stat.edge_ab)) begin
                            cmd.fold   = 1'b1;
                            state_next = S_FOLD;
                        end
                    end
                    default: ;
                endcase
            end
            S_FOLD: begin
                state_next = S_SWEEP;
            end
            S_SWEEP: begin
                cmd.sweep = 1'b1;
                if (stat.sweep_last) begin
                    cmd.finish = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                m_valid_next = 1'b1;
                state_next   = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            func_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            func_reg    <= func_next;
        end
    end

    `include "graph_vertex_merge_engine_core_defines.svh"
    `GVM_ASSERT_IMP(a_ready_idle, aclk, aresetn, s_ready, state_reg == S_IDLE, "ready outside idle")
    `GVM_ASSERT_NEXT(a_load_eval, aclk, aresetn, s_valid && s_ready, state_reg == S_EVAL, "no eval")
    `GVM_ASSERT_NEXT(a_done_valid, aclk, aresetn, state_reg == S_DONE, m_valid_reg, "no result")

endmodule

// File: rtl/core/gvme_dp.sv
module gvme_dp #(
    parameter int MAX_VERTICES = gvme_pkg::MAX_VERTICES_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [2:0]              s_func,
    input  logic [5:0]              s_vertex_a,
    input  logic [5:0]              s_vertex_b,
    input  logic [5:0]              s_vertex_count,
    input  gvme_pkg::dp_cmd_t       cmd,
    output gvme_pkg::dp_stat_t      stat,
    output logic [1:0]              m_status,
    output logic                    m_edge_present,
    output logic [31:0]             m_row_bits,
    output logic [5:0]              m_vertex_total
);

    localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam logic [6:0] MAXV = 7'(MAX_VERTICES);

    logic [MAX_VERTICES-1:0] adj_reg [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] adj_next [MAX_VERTICES];
    logic [6:0]  live_reg, live_next;
    logic [6:0]  live_dec;
    logic [2:0]  func_reg;
    logic [5:0]  a_reg, b_reg, cnt_reg;
    logic [IW-1:0] idx_reg, idx_next;
    logic [6:0]  idx_w;
    logic [1:0]  status_reg;
    logic        present_reg;
    logic [31:0] row_out_reg;
    logic [MAX_VERTICES-1:0] row_a, row_b, src, shifted, lowm, cleaned;
    logic        a_ok, b_ok, eab;
    logic [IW-1:0] ai, bi;

    assign ai   = a_reg[IW-1:0];
    assign bi   = b_reg[IW-1:0];
    assign a_ok = {1'b0, a_reg} < live_reg;
    assign b_ok = {1'b0, b_reg} < live_reg;
    assign row_a = adj_reg[ai];
    assign row_b = adj_reg[bi];
    assign eab  = row_a[bi];
    assign idx_w    = 7'(idx_reg);
    assign live_dec = live_reg - 7'd1;

    assign stat.a_ok       = a_ok;
    assign stat.b_ok       = b_ok;
    assign stat.same       = (a_reg == b_reg);
    assign stat.edge_ab    = eab;
    assign stat.sweep_last = (idx_w + 7'd2 >= live_reg);

    // Sweep row idx: new row idx takes old row idx (below b) or idx+1 (at or above b);
    // the in-edge fold and self-loop drop use the source index, then column b drops out.
    logic [IW:0] sidx_w;
    logic [IW-1:0] sidx;
    assign sidx_w = (idx_reg >= bi) ? {1'b0, idx_reg} + 1'b1 : {1'b0, idx_reg};
    assign sidx   = sidx_w[IW-1:0];

    always_comb begin
        src = adj_reg[sidx];
        if (src[bi]) src[ai] = 1'b1;
        src[sidx] = 1'b0;
        cleaned = src;
        lowm    = (MAX_VERTICES'(1) << bi) - 1'b1;
        shifted = (cleaned >> 1) & ~lowm;
        cleaned = (cleaned & lowm) | shifted;
    end

    always_comb begin
        for (int i = 0; i < MAX_VERTICES; i++) adj_next[i] = adj_reg[i];
        live_next = live_reg;
        idx_next  = idx_reg;
        if (cmd.clear) begin
            for (int i = 0; i < MAX_VERTICES; i++) adj_next[i] = '0;
            live_next = ({1'b0, cnt_reg} > MAXV) ? MAXV : {1'b0, cnt_reg};
        end
        if (cmd.edge_op) begin
            adj_next[ai][bi] = (func_reg == gvme_pkg::FUNC_ADD);
        end
        if (cmd.fold) begin
            adj_next[ai] = row_a | row_b;
            idx_next = '0;
        end
        if (cmd.sweep) begin
            // row idx+1 must be read before it is overwritten: rows move down only
            adj_next[idx_reg] = cleaned;
            idx_next = idx_reg + 1'b1;
        end
        if (cmd.finish) begin
            adj_next[live_reg[IW-1:0] - 1'b1] = '0;
            if (live_reg == 7'd2) adj_next[0] = cleaned;
            live_next = live_dec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_VERTICES; i++) adj_reg[i] <= '0;
            live_reg <= '0;
        end else begin
            for (int i = 0; i < MAX_VERTICES; i++) adj_reg[i] <= adj_next[i];
            live_reg <= live_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (cmd.load) begin
            func_reg <= s_func;
            a_reg    <= s_vertex_a;
            b_reg    <= s_vertex_b;
            cnt_reg  <= s_vertex_count;
        end
    end

    // Result is decided during evaluation, before the graph moves.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            status_reg  <= gvme_pkg::ST_OK;
            present_reg <= 1'b0;
            row_out_reg <= '0;
        end else if (cmd.evaluate) begin
            unique case (func_reg)
                gvme_pkg::FUNC_NEW: begin
                    if ({1'b0, cnt_reg} > MAXV) status_reg <= gvme_pkg::ST_BAD_VERTEX;
                end
                gvme_pkg::FUNC_ADD, gvme_pkg::FUNC_REMOVE: begin
                    if (!(a_ok && b_ok)) status_reg <= gvme_pkg::ST_BAD_VERTEX;
                end
                gvme_pkg::FUNC_QUERY: begin
                    if (!(a_ok && b_ok)) status_reg <= gvme_pkg::ST_BAD_VERTEX;
                    else present_reg <= eab;
                end
                gvme_pkg::FUNC_IDENT, gvme_pkg::FUNC_CONTR: begin
                    if (!(a_ok && b_ok) || a_reg == b_reg)
                        status_reg <= gvme_pkg::ST_BAD_VERTEX;
                    else if (func_reg == gvme_pkg::FUNC_CONTR && !eab)
                        status_reg <= gvme_pkg::ST_NO_EDGE;
                end
                gvme_pkg::FUNC_READ: begin
                    if (!a_ok) status_reg <= gvme_pkg::ST_BAD_VERTEX;
                    else row_out_reg <= 32'(row_a);
                end
                default: ;
            endcase
        end
    end

    assign m_status       = status_reg;
    assign m_edge_present = present_reg;
    assign m_row_bits     = row_out_reg;
    assign m_vertex_total = live_reg[5:0];

    `include "graph_vertex_merge_engine_core_defines.svh"
    `GVM_ASSERT_IMP(a_live_max, aclk, aresetn, 1'b1, live_reg <= MAXV, "count above max")
    `GVM_ASSERT_NEXT(a_finish_dec, aclk, aresetn, cmd.finish, live_reg == $past(live_dec), "no dec")
    `GVM_ASSERT_IMP(a_sweep_range, aclk, aresetn, cmd.sweep, idx_w + 7'd1 < live_reg, "sweep past end")

endmodule

// File: verif/tb_graph_vertex_merge_engine_core.sv
`timescale 1ns / 1ps

module tb_graph_vertex_merge_engine_core;

    localparam int NV = gvme_pkg::MAX_VERTICES_DEF;
    localparam int STALL_LIMIT = 20000;
    localparam logic [2:0] FUNC_UNUSED = 3'd7;

    // Expected result of one operation
    typedef struct {
        logic [1:0]  status;
        logic        edge_present;
        logic [31:0] row_bits;
        logic [5:0]  vertex_total;
    } graph_answer_t;

    // Shadow of the block's graph plus the queue of answers still owed
    class graph_scoreboard;
        logic [31:0]   rows [NV];
        int unsigned   live;
        graph_answer_t owed [$];
        int unsigned   errors;

        function new();
            foreach (rows[i]) rows[i] = '0;
            live = 0;
            errors = 0;
        endfunction

        function void merge_rows(int unsigned a, int unsigned b);
            int unsigned n;
            logic [31:0] r;
            n = live;
            rows[a] |= rows[b];
            for (int unsigned i = 0; i < n; i++)
                if (rows[i][b]) rows[i][a] = 1'b1;
            for (int unsigned i = 0; i < n; i++) rows[i][i] = 1'b0;
            for (int unsigned i = b; i + 1 < n; i++) rows[i] = rows[i + 1];
            rows[n - 1] = '0;
            for (int unsigned i = 0; i + 1 < n; i++) begin
                r = '0;
                for (int unsigned j = 0; j < NV; j++) begin
                    if (j < b) r[j] = rows[i][j];
                    else if (j + 1 < NV) r[j] = rows[i][j + 1];
                end
                rows[i] = r;
            end
            live = n - 1;
        endfunction

        function void note_input(logic [2:0] fn, logic [5:0] a, logic [5:0] b,
                                 logic [5:0] cnt);
            graph_answer_t ans;
            logic a_ok, b_ok;
            ans = '{gvme_pkg::ST_OK, 1'b0, 32'd0, 6'd0};
            a_ok = a < live;
            b_ok = b < live;
            case (fn)
                gvme_pkg::FUNC_NEW: begin
                    foreach (rows[i]) rows[i] = '0;
                    if (cnt > NV) begin
                        live = NV;
                        ans.status = gvme_pkg::ST_BAD_VERTEX;
                    end else begin
                        live = cnt;
                    end
                end
                gvme_pkg::FUNC_ADD, gvme_pkg::FUNC_REMOVE, gvme_pkg::FUNC_QUERY: begin
                    if (!a_ok || !b_ok) ans.status = gvme_pkg::ST_BAD_VERTEX;
                    else if (fn == gvme_pkg::FUNC_ADD) rows[a][b] = 1'b1;
                    else if (fn == gvme_pkg::FUNC_REMOVE) rows[a][b] = 1'b0;
                    else ans.edge_present = rows[a][b];
                end
                gvme_pkg::FUNC_IDENT, gvme_pkg::FUNC_CONTR: begin
                    if (!a_ok || !b_ok || a == b) ans.status = gvme_pkg::ST_BAD_VERTEX;
                    else if (fn == gvme_pkg::FUNC_CONTR && !rows[a][b])
                        ans.status = gvme_pkg::ST_NO_EDGE;
                    else merge_rows(a, b);
                end
                gvme_pkg::FUNC_READ: begin
                    if (!a_ok) ans.status = gvme_pkg::ST_BAD_VERTEX;
                    else ans.row_bits = rows[a];
                end
                default: ;
            endcase
            ans.vertex_total = live[5:0];
            owed.push_back(ans);
        endfunction

        function void check_result(logic [1:0] st, logic ep, logic [31:0] rb,
                                   logic [5:0] vt);
            graph_answer_t e;
            if (owed.size() == 0) begin
                $error("result beat with nothing outstanding");
                errors++;
                return;
            end
            e = owed.pop_front();
            if (st !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, st);
                errors++;
            end
            if (ep !== e.edge_present) begin
                $error("edge_present: expected %0d, got %0d", e.edge_present, ep);
                errors++;
            end
            if (rb !== e.row_bits) begin
                $error("row_bits: expected %h, got %h", e.row_bits, rb);
                errors++;
            end
            if (vt !== e.vertex_total) begin
                $error("vertex_total: expected %0d, got %0d", e.vertex_total, vt);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_func = '0;
    logic [5:0]  s_vertex_a = '0;
    logic [5:0]  s_vertex_b = '0;
    logic [5:0]  s_vertex_count = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic        m_edge_present;
    logic [31:0] m_row_bits;
    logic [5:0]  m_vertex_total;

    graph_scoreboard board = new();

    // Idle rates in percent; the stimulus process switches them per phase
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_off_cycles = 0;
    int unsigned quiet_cycles = 0;

    graph_vertex_merge_engine_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_func(s_func), .s_vertex_a(s_vertex_a), .s_vertex_b(s_vertex_b),
        .s_vertex_count(s_vertex_count),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_status(m_status), .m_edge_present(m_edge_present),
        .m_row_bits(m_row_bits), .m_vertex_total(m_vertex_total)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Sample both channels at the rising edge: note input beats, check result beats
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                board.note_input(s_func, s_vertex_a, s_vertex_b, s_vertex_count);
            if (m_valid && m_ready)
                board.check_result(m_status, m_edge_present, m_row_bits, m_vertex_total);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog: too long without any beat means the block has hung
    always @(posedge aclk) begin
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: drive ready at the falling edge; a requested hold-off keeps it low
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_off_cycles != 0) begin
            m_ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Offer one beat and hold it until taken; valid drops only while the sender idles
    task automatic send_item(input logic [2:0] fn, input logic [5:0] a,
                             input logic [5:0] b, input logic [5:0] cnt);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= fn;
        s_vertex_a <= a;
        s_vertex_b <= b;
        s_vertex_count <= cnt;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Drop valid and hold the sender until every owed answer is back
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (board.owed.size() != 0) @(negedge aclk);
    endtask

    // Pick a vertex mostly in range, sometimes just past the count or anywhere in 0..63
    function automatic logic [5:0] pick_vertex();
        int unsigned r;
        r = $urandom_range(99);
        if (board.live != 0 && r < 85) return 6'($urandom_range(board.live - 1));
        if (r < 93) return board.live[5:0];
        return 6'($urandom_range(63));
    endfunction

    task automatic random_item();
        int unsigned r;
        logic [2:0] fn;
        logic [5:0] a, b;
        r = $urandom_range(99);
        // Keep graphs small and rebuilt often so merges run on dense state
        if (board.live < 2 && r < 70) fn = gvme_pkg::FUNC_NEW;
        else if (r < 4) fn = gvme_pkg::FUNC_NEW;
        else if (r < 40) fn = gvme_pkg::FUNC_ADD;
        else if (r < 48) fn = gvme_pkg::FUNC_REMOVE;
        else if (r < 58) fn = gvme_pkg::FUNC_QUERY;
        else if (r < 70) fn = gvme_pkg::FUNC_IDENT;
        else if (r < 82) fn = gvme_pkg::FUNC_CONTR;
        else if (r < 97) fn = gvme_pkg::FUNC_READ;
        else fn = 3'($urandom_range(7));
        a = pick_vertex();
        b = pick_vertex();
        // Contract needs an existing edge often enough to succeed
        if (fn == gvme_pkg::FUNC_CONTR && board.live > 1 && a < board.live &&
            $urandom_range(1) == 1)
            for (int unsigned j = 0; j < board.live; j++)
                if (board.rows[a][j] && j != a) b = 6'(j);
        send_item(fn, a, b, ($urandom_range(9) == 0) ? 6'($urandom_range(63))
                                                     : 6'($urandom_range(32, 2)));
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: special cases and field extremes
        send_item(gvme_pkg::FUNC_ADD, 6'd0, 6'd0, 6'd0);      // no vertices yet
        send_item(gvme_pkg::FUNC_NEW, 6'd0, 6'd0, 6'd63);     // count too large
        send_item(gvme_pkg::FUNC_ADD, 6'd31, 6'd0, 6'd0);
        send_item(gvme_pkg::FUNC_ADD, 6'd0, 6'd31, 6'd0);
        send_item(gvme_pkg::FUNC_ADD, 6'd5, 6'd5, 6'd0);      // self-loop
        send_item(gvme_pkg::FUNC_QUERY, 6'd5, 6'd5, 6'd0);
        send_item(gvme_pkg::FUNC_READ, 6'd0, 6'd0, 6'd0);
        send_item(gvme_pkg::FUNC_ADD, 6'd63, 6'd63, 6'd0);    // out of range
        send_item(gvme_pkg::FUNC_READ, 6'd32, 6'd0, 6'd0);
        send_item(gvme_pkg::FUNC_IDENT, 6'd3, 6'd3, 6'd0);    // merge with itself
        send_item(gvme_pkg::FUNC_CONTR, 6'd1, 6'd2, 6'd0);    // missing edge
        send_item(gvme_pkg::FUNC_CONTR, 6'd0, 6'd31, 6'd0);
        send_item(gvme_pkg::FUNC_IDENT, 6'd0, 6'd30, 6'd0);
        send_item(gvme_pkg::FUNC_READ, 6'd0, 6'd0, 6'd0);
        send_item(gvme_pkg::FUNC_REMOVE, 6'd0, 6'd4, 6'd0);
        send_item(FUNC_UNUSED, 6'd42, 6'd21, 6'd21);
        send_item(gvme_pkg::FUNC_NEW, 6'd0, 6'd0, 6'd32);
        send_item(gvme_pkg::FUNC_NEW, 6'd0, 6'd0, 6'd0);
        send_item(gvme_pkg::FUNC_QUERY, 6'd0, 6'd0, 6'd0);
        send_item(gvme_pkg::FUNC_NEW, 6'd0, 6'd0, 6'd2);
        send_item(gvme_pkg::FUNC_ADD, 6'd1, 6'd0, 6'd0);
        send_item(gvme_pkg::FUNC_IDENT, 6'd1, 6'd0, 6'd0);
        send_item(gvme_pkg::FUNC_READ, 6'd0, 6'd0, 6'd0);

        // Phase one: sender idles rarely, receiver often
        send_idle_pct = 8;
        recv_idle_pct = 69;
        repeat (380) random_item();

        // Long receiver hold-off while items keep coming; block must stall input
        hold_off_cycles = 300;
        repeat (20) random_item();
        wait_drained();

        // Phase two: roles swapped
        send_idle_pct = 69;
        recv_idle_pct = 8;
        repeat (380) random_item();
        wait_drained();

        // Phase three: full speed
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (380) random_item();

        wait_drained();
        repeat (60) @(posedge aclk);
        if (board.errors == 0 && board.owed.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/gvme_pkg.sv
rtl/core/gvme_ctrl.sv
rtl/core/gvme_dp.sv
rtl/core/graph_vertex_merge_engine_core.sv
verif/tb_graph_vertex_merge_engine_core.sv
